>>> rtl/crz_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crz_pkg
// Shared constants and types for the circle rasterizer.
// ----------------------------------------------------------------------------
package crz_pkg;

  localparam int CRZ_COORD_BITS  = 16;
  localparam int CRZ_RADIUS_BITS = 12;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } crz_op_t;

  typedef struct packed {
    logic end_iter;
    logic last;
  } crz_ctl_t;

endpackage
`default_nettype wire

>>> rtl/crz_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crz_if
// Valid/ready channels of the circle rasterizer: commands in, primitives out.
// ----------------------------------------------------------------------------
interface crz_in_if import crz_pkg::*; #(
  parameter int COORD_BITS  = CRZ_COORD_BITS,
  parameter int RADIUS_BITS = CRZ_RADIUS_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [RADIUS_BITS-1:0] radius;
  logic                          fill_mode;

  modport source (output valid, op, center_x, center_y, radius, fill_mode, input ready);
  modport sink   (input valid, op, center_x, center_y, radius, fill_mode, output ready);
endinterface

interface crz_out_if import crz_pkg::*; #(
  parameter int COORD_BITS = CRZ_COORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [COORD_BITS:0]  left_x;
  logic signed [COORD_BITS:0]  row_y;
  logic signed [COORD_BITS:0]  right_x;
  logic                        last_of_run;

  modport source (output valid, left_x, row_y, right_x, last_of_run, input ready);
  modport sink   (input valid, left_x, row_y, right_x, last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/crz_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crz_step
// One step of the circle walk: selects the current primitive and computes the
// next step coordinates and decision value.
// ----------------------------------------------------------------------------
module crz_step import crz_pkg::*; #(
  parameter int COORD_BITS  = CRZ_COORD_BITS,
  parameter int RADIUS_BITS = CRZ_RADIUS_BITS
) (
  input  wire logic signed [COORD_BITS-1:0]  cx,
  input  wire logic signed [COORD_BITS-1:0]  cy,
  input  wire logic        [RADIUS_BITS-1:0] rad,
  input  wire logic        [RADIUS_BITS-1:0] sx,
  input  wire logic        [RADIUS_BITS-1:0] sy,
  input  wire logic signed [RADIUS_BITS+2:0] dec,
  input  wire logic        [2:0]             sub,
  input  wire logic                          filled,
  output logic signed      [COORD_BITS:0]    lx,
  output logic signed      [COORD_BITS:0]    ry,
  output logic signed      [COORD_BITS:0]    rx,
  output crz_ctl_t                           ctl,
  output logic             [RADIUS_BITS-1:0] sx_nxt,
  output logic             [RADIUS_BITS-1:0] sy_nxt,
  output logic signed      [RADIUS_BITS+2:0] dec_nxt
);

  localparam int OB = COORD_BITS + 1;
  localparam int SW = (RADIUS_BITS > OB) ? RADIUS_BITS : OB;
  localparam int DB = RADIUS_BITS + 3;
  localparam int WB = RADIUS_BITS + 4;
  localparam int NB = RADIUS_BITS + 2;
  localparam logic signed [WB-1:0] ONE_W = WB'(1);
  localparam logic signed [NB-1:0] ONE_N = NB'(1);

  logic        [SW-1:0] sx_w, sy_w;
  logic signed [OB-1:0] cxo, cyo, sxo, syo;
  logic signed [OB-1:0] cx_psx, cx_msx, cx_psy, cx_msy;
  logic signed [OB-1:0] cy_psx, cy_msx, cy_psy, cy_msy;
  logic signed [WB-1:0] d_w, sx_x, sy_x, rad_x, d_new;
  logic signed [NB-1:0] nx, ny, sx_n, sy_n;

  assign sx_w = SW'(sx);
  assign sy_w = SW'(sy);
  assign cxo  = OB'(cx);
  assign cyo  = OB'(cy);
  assign sxo  = $signed(sx_w[OB-1:0]);
  assign syo  = $signed(sy_w[OB-1:0]);

  assign cx_psx = cxo + sxo;
  assign cx_msx = cxo - sxo;
  assign cx_psy = cxo + syo;
  assign cx_msy = cxo - syo;
  assign cy_psx = cyo + sxo;
  assign cy_msx = cyo - sxo;
  assign cy_psy = cyo + syo;
  assign cy_msy = cyo - syo;

  always_comb begin
    lx = cx_psx;
    rx = cx_psx;
    ry = cy_psy;
    if (filled) begin
      case (sub[1:0])
        2'd0: begin lx = cx_msy; rx = cx_psy; ry = cy_psx; end
        2'd1: begin lx = cx_msx; rx = cx_psx; ry = cy_psy; end
        2'd2: begin lx = cx_msx; rx = cx_psx; ry = cy_msy; end
        default: begin lx = cx_msy; rx = cx_psy; ry = cy_msx; end
      endcase
    end else begin
      case (sub)
        3'd0: begin lx = cx_psx; ry = cy_psy; end
        3'd1: begin lx = cx_psy; ry = cy_psx; end
        3'd2: begin lx = cx_msx; ry = cy_psy; end
        3'd3: begin lx = cx_msy; ry = cy_psx; end
        3'd4: begin lx = cx_psx; ry = cy_msy; end
        3'd5: begin lx = cx_psy; ry = cy_msx; end
        3'd6: begin lx = cx_msx; ry = cy_msy; end
        default: begin lx = cx_msy; ry = cy_msx; end
      endcase
      rx = lx;
    end
  end

  assign d_w   = WB'(dec);
  assign sx_x  = WB'($signed({1'b0, sx}));
  assign sy_x  = WB'($signed({1'b0, sy}));
  assign rad_x = WB'($signed({1'b0, rad}));
  assign sx_n  = NB'($signed({1'b0, sx}));
  assign sy_n  = NB'($signed({1'b0, sy}));

  always_comb begin
    if (d_w >= (sx_x <<< 1)) begin
      d_new = d_w - (sx_x <<< 1) - ONE_W;
      nx    = sx_n + ONE_N;
      ny    = sy_n;
    end else if (d_w < ((rad_x - sy_x) <<< 1)) begin
      d_new = d_w + (sy_x <<< 1) - ONE_W;
      nx    = sx_n;
      ny    = sy_n - ONE_N;
    end else begin
      d_new = d_w + ((sy_x - sx_x - ONE_W) <<< 1);
      nx    = sx_n + ONE_N;
      ny    = sy_n - ONE_N;
    end
  end

  assign ctl.end_iter = filled ? (sub >= 3'd3) : (sub >= 3'd7);
  assign ctl.last     = ctl.end_iter && (ny < nx);
  assign sx_nxt       = nx[RADIUS_BITS-1:0];
  assign sy_nxt       = ny[RADIUS_BITS-1:0];
  assign dec_nxt      = d_new[DB-1:0];

endmodule
`default_nettype wire

>>> rtl/circle_rasterizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circle_rasterizer
// Integer circle walk (Andres stepping) emitting one point or span per tick.
// ----------------------------------------------------------------------------
// A start beat loads center, radius and mode and gives no result. Each tick
// beat then gives one primitive: eight symmetric points per step in outline
// mode, four horizontal spans per step in fill mode; the final one carries
// last_of_run. A beat is taken every clock while the result register is empty
// or being drained; each result is registered and shown in the cycle after its
// tick. Ticks while idle give nothing; a start abandons any circle in progress.
// ----------------------------------------------------------------------------
module circle_rasterizer import crz_pkg::*; #(
  parameter int COORD_BITS  = CRZ_COORD_BITS,
  parameter int RADIUS_BITS = CRZ_RADIUS_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  crz_in_if.sink    in_bus,
  crz_out_if.source out_bus
);

  localparam int OB = COORD_BITS + 1;
  localparam int DB = RADIUS_BITS + 3;

  logic                          busy_r, busy_nxt;
  logic                          filled_r, filled_nxt;
  logic signed [COORD_BITS-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic        [RADIUS_BITS-1:0] rad_r, rad_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [DB-1:0]          dec_r, dec_nxt;
  logic        [2:0]             sub_r, sub_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [OB-1:0]          lx_r, lx_nxt, ry_r, ry_nxt, rx_r, rx_nxt;
  logic                          last_r, last_nxt;

  logic signed [OB-1:0]          st_lx, st_ry, st_rx;
  crz_ctl_t                      st_ctl;
  logic        [RADIUS_BITS-1:0] st_sx, st_sy;
  logic signed [DB-1:0]          st_dec;
  logic                          accept;

  crz_step #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_step (
    .cx      (cx_r),
    .cy      (cy_r),
    .rad     (rad_r),
    .sx      (sx_r),
    .sy      (sy_r),
    .dec     (dec_r),
    .sub     (sub_r),
    .filled  (filled_r),
    .lx      (st_lx),
    .ry      (st_ry),
    .rx      (st_rx),
    .ctl     (st_ctl),
    .sx_nxt  (st_sx),
    .sy_nxt  (st_sy),
    .dec_nxt (st_dec)
  );

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;

  always_comb begin
    busy_nxt      = busy_r;
    filled_nxt    = filled_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rad_nxt       = rad_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    dec_nxt       = dec_r;
    sub_nxt       = sub_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    lx_nxt        = lx_r;
    ry_nxt        = ry_r;
    rx_nxt        = rx_r;
    last_nxt      = last_r;
    if (accept) begin
      if (crz_op_t'(in_bus.op) == OP_START) begin
        busy_nxt   = 1'b1;
        filled_nxt = in_bus.fill_mode;
        cx_nxt     = in_bus.center_x;
        cy_nxt     = in_bus.center_y;
        rad_nxt    = in_bus.radius;
        sx_nxt     = '0;
        sy_nxt     = in_bus.radius;
        dec_nxt    = $signed(DB'(in_bus.radius) - DB'(1));
        sub_nxt    = '0;
      end else if (busy_r) begin
        out_valid_nxt = 1'b1;
        lx_nxt        = st_lx;
        ry_nxt        = st_ry;
        rx_nxt        = st_rx;
        last_nxt      = st_ctl.last;
        if (st_ctl.end_iter) begin
          sub_nxt = '0;
          if (st_ctl.last) begin
            busy_nxt = 1'b0;
          end else begin
            sx_nxt  = st_sx;
            sy_nxt  = st_sy;
            dec_nxt = st_dec;
          end
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    filled_r <= filled_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    rad_r    <= rad_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    dec_r    <= dec_nxt;
    lx_r     <= lx_nxt;
    ry_r     <= ry_nxt;
    rx_r     <= rx_nxt;
    last_r   <= last_nxt;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.left_x      = lx_r;
  assign out_bus.row_y       = ry_r;
  assign out_bus.right_x     = rx_r;
  assign out_bus.last_of_run = last_r;

endmodule
`default_nettype wire
